[rtl/mdtp_pkg.sv]
// Shared types and codes for the meter datapoint parser.
// No dependencies; imported by the parser, result sequencer and top level.
`default_nettype none

package mdtp_pkg;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_RAW_TYPE_CODE   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_DATA_LENGTH = 1'd1;

  localparam logic [15:0] MAX_DATA_LENGTH_RESET = 16'd256;

  // parse phase codes
  localparam logic [1:0] PH_WAIT   = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_HEADER = 2'd2;
  localparam logic [1:0] PH_DATA   = 2'd3;

  // width codes
  localparam logic [1:0] WC_8  = 2'd0;
  localparam logic [1:0] WC_16 = 2'd1;
  localparam logic [1:0] WC_32 = 2'd2;

  // One finished datapoint. A phase datapoint carries voltage in value and
  // the two further readings in curr and pwr.
  typedef struct packed {
    logic        phase;
    logic [7:0]  attr;
    logic [31:0] value;
    logic [1:0]  wc;
    logic [23:0] curr;
    logic [23:0] pwr;
  } mdtp_result_t;

endpackage

`default_nettype wire

[rtl/meter_datapoint_tlv_parser.sv]
// Meter datapoint parser top level: config registers, parser, result sequencer.
// Each result is registered in the parser, then in the sequencer's output register.
// Throughput: one byte per cycle; input stalls only while a finished datapoint
// waits behind a stalled output or behind a phase datapoint's three output transfers.
// Reset (rst, synchronous): parser waits for a message start, output empty,
// raw_type_code = 0, max_data_length = 256.
`default_nettype none

module meter_datapoint_tlv_parser
  import mdtp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             data_byte,
  input  logic                   first_byte,
  input  logic                   last_byte,
  input  logic                   status_report,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             attribute_id,
  output logic [31:0]            reading,
  output logic [1:0]             width_code,
  output logic                   last_of_run,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data
);

  logic [7:0]   raw_type_code;
  logic [15:0]  max_data_length;
  logic         bundle_valid;
  logic         bundle_take;
  mdtp_result_t bundle;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_type_code   <= 8'd0;
      max_data_length <= MAX_DATA_LENGTH_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RAW_TYPE_CODE:   raw_type_code   <= wr_data[7:0];
        REG_MAX_DATA_LENGTH: max_data_length <= wr_data[15:0];
      endcase
    end
  end

  mdtp_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .first_byte      (first_byte),
    .last_byte       (last_byte),
    .status_report   (status_report),
    .raw_type_code   (raw_type_code),
    .max_data_length (max_data_length),
    .bundle_valid    (bundle_valid),
    .bundle          (bundle),
    .bundle_take     (bundle_take)
  );

  mdtp_result_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .bundle_valid (bundle_valid),
    .bundle       (bundle),
    .bundle_take  (bundle_take),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .attribute_id (attribute_id),
    .reading      (reading),
    .width_code   (width_code),
    .last_of_run  (last_of_run)
  );

endmodule

`default_nettype wire

[rtl/mdtp_parser.sv]
// Byte-level datapoint parser: header/data tracking, id mapping, result stage.
// Depends on mdtp_pkg; feeds mdtp_result_seq.
`default_nettype none

module mdtp_parser
  import mdtp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [7:0]   data_byte,
  input  logic         first_byte,
  input  logic         last_byte,
  input  logic         status_report,
  input  logic [7:0]   raw_type_code,
  input  logic [15:0]  max_data_length,
  output logic         bundle_valid,
  output mdtp_result_t bundle,
  input  logic         bundle_take
);

  typedef struct packed {
    logic [7:0] attr;
    logic [1:0] wc;
  } map_t;

  function automatic map_t map_id(input logic [7:0] id, input logic [15:0] len);
    map_t m;
    m.attr = id;
    m.wc   = WC_32;
    unique case (id)
      8'd1, 8'd32:   m.attr = 8'd1;
      8'd2:          m.attr = 8'd2;
      8'd15:         m.attr = 8'd15;
      8'd16:         begin m.attr = 8'd16;  m.wc = WC_8;  end
      8'd18, 8'd104: m.attr = 8'd101;
      8'd19, 8'd105: m.attr = 8'd102;
      8'd20, 8'd103: begin m.attr = 8'd100; m.wc = WC_16; end
      8'd101:        begin m.attr = 8'd201; m.wc = WC_16; end
      8'd111:        m.attr = 8'd200;
      8'd112:        begin m.attr = 8'd110; m.wc = WC_16; end
      8'd107, 8'd113: m.attr = 8'd111;
      8'd108, 8'd114: m.attr = 8'd112;
      8'd109, 8'd121: begin m.attr = 8'd120; m.wc = WC_16; end
      8'd110, 8'd122: m.attr = 8'd121;
      8'd123:        m.attr = 8'd122;
      default: begin
        m.attr = id;
        if (len == 16'd1)      m.wc = WC_8;
        else if (len == 16'd2) m.wc = WC_16;
        else                   m.wc = WC_32;
      end
    endcase
    return m;
  endfunction

  function automatic logic [31:0] mask_value(input logic [31:0] v, input logic [1:0] wc);
    logic [31:0] r;
    if (wc == WC_8)       r = {24'd0, v[7:0]};
    else if (wc == WC_16) r = {16'd0, v[15:0]};
    else                  r = v;
    return r;
  endfunction

  logic [1:0]  parse_phase,  parse_phase_next;
  logic [1:0]  header_index, header_index_next;
  logic [1:0]  skip_count,   skip_count_next;
  logic [7:0]  point_id,     point_id_next;
  logic [7:0]  point_type,   point_type_next;
  logic [15:0] point_length, point_length_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [3:0]  data_index,   data_index_next;   // saturates at 8
  logic [31:0] value_accumulator, value_accumulator_next;
  logic [63:0] phase_bytes,  phase_bytes_next;

  logic [1:0]  eph, ehi, esk;
  logic [15:0] erem, elen;
  logic [31:0] eacc;
  logic        emit;
  logic        is_phase;
  logic [7:0]  phase_base;
  map_t        mapped;
  mdtp_result_t result;
  logic        in_accept;

  assign in_stall  = bundle_valid && !bundle_take;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    eph  = parse_phase;
    ehi  = header_index;
    esk  = skip_count;
    erem = bytes_remaining;
    elen = point_length;
    eacc = value_accumulator;
    if (first_byte) begin
      ehi  = 2'd0;
      erem = 16'd0;
      elen = 16'd0;
      eacc = 32'd0;
      eph  = status_report ? PH_SKIP : PH_HEADER;
      esk  = status_report ? 2'd2 : 2'd0;
    end

    parse_phase_next       = eph;
    header_index_next      = ehi;
    skip_count_next        = esk;
    bytes_remaining_next   = erem;
    point_length_next      = elen;
    value_accumulator_next = eacc;
    point_id_next          = point_id;
    point_type_next        = point_type;
    data_index_next        = data_index;
    phase_bytes_next       = phase_bytes;
    emit                   = 1'b0;

    unique case (eph)
      PH_SKIP: begin
        skip_count_next = esk - 2'd1;
        if (skip_count_next == 2'd0) begin
          parse_phase_next  = PH_HEADER;
          header_index_next = 2'd0;
        end
      end
      PH_HEADER: begin
        unique case (ehi)
          2'd0: begin
            point_id_next          = data_byte;
            value_accumulator_next = 32'd0;
            header_index_next      = 2'd1;
          end
          2'd1: begin
            point_type_next   = data_byte;
            header_index_next = 2'd2;
          end
          2'd2: begin
            point_length_next = {data_byte, 8'd0};
            header_index_next = 2'd3;
          end
          2'd3: begin
            point_length_next = {elen[15:8], data_byte};
            header_index_next = 2'd0;
            priority if (last_byte) begin
              parse_phase_next = PH_WAIT;
            end else if (point_length_next > max_data_length) begin
              parse_phase_next = PH_WAIT;
            end else if (point_length_next == 16'd0) begin
              emit = 1'b1;
            end else begin
              bytes_remaining_next = point_length_next;
              data_index_next      = 4'd0;
              parse_phase_next     = PH_DATA;
            end
          end
        endcase
      end
      PH_DATA: begin
        if (data_index < 4'd4)
          value_accumulator_next = {eacc[23:0], data_byte};
        if (data_index < 4'd8) begin
          phase_bytes_next = {phase_bytes[55:0], data_byte};
          data_index_next  = data_index + 4'd1;
        end
        bytes_remaining_next = erem - 16'd1;
        if (bytes_remaining_next == 16'd0) begin
          emit              = 1'b1;
          parse_phase_next  = PH_HEADER;
          header_index_next = 2'd0;
        end
      end
      PH_WAIT: begin
      end
    endcase

    if (last_byte)
      parse_phase_next = PH_WAIT;
  end

  // result for a datapoint completed by this byte
  always_comb begin
    is_phase = (point_id >= 8'd6) && (point_id <= 8'd8) &&
               (point_type == raw_type_code) && (point_length_next >= 16'd8);
    unique case (point_id)
      8'd6:    phase_base = 8'd100;
      8'd7:    phase_base = 8'd110;
      default: phase_base = 8'd120;
    endcase
    mapped = map_id(point_id, point_length_next);
    if (is_phase) begin
      result.phase = 1'b1;
      result.attr  = phase_base;
      result.value = {16'd0, phase_bytes_next[63:48]};
      result.wc    = WC_16;
    end else begin
      result.phase = 1'b0;
      result.attr  = mapped.attr;
      result.value = mask_value(value_accumulator_next, mapped.wc);
      result.wc    = mapped.wc;
    end
    result.curr = phase_bytes_next[47:24];
    result.pwr  = phase_bytes_next[23:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= PH_WAIT;
      header_index      <= 2'd0;
      skip_count        <= 2'd0;
      point_id          <= 8'd0;
      point_type        <= 8'd0;
      point_length      <= 16'd0;
      bytes_remaining   <= 16'd0;
      data_index        <= 4'd0;
      value_accumulator <= 32'd0;
      phase_bytes       <= 64'd0;
      bundle_valid      <= 1'b0;
    end else begin
      bundle_valid <= (bundle_valid && !bundle_take) || (in_accept && emit);
      if (in_accept) begin
        parse_phase       <= parse_phase_next;
        header_index      <= header_index_next;
        skip_count        <= skip_count_next;
        point_id          <= point_id_next;
        point_type        <= point_type_next;
        point_length      <= point_length_next;
        bytes_remaining   <= bytes_remaining_next;
        data_index        <= data_index_next;
        value_accumulator <= value_accumulator_next;
        phase_bytes       <= phase_bytes_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit)
      bundle <= result;
  end

`ifndef SYNTHESIS
  a_bundle_held: assert property (@(posedge clk) disable iff (rst)
    bundle_valid && !bundle_take |=> bundle_valid && $stable(bundle))
    else $error("pending datapoint result lost or changed");
  a_skip_count: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_SKIP |-> skip_count == 2'd1)
    else $error("sequence byte count out of step");
  a_data_remaining: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_DATA |-> bytes_remaining != 16'd0)
    else $error("data phase with nothing left to read");
`endif

endmodule

`default_nettype wire

[rtl/mdtp_result_seq.sv]
// Output register and sequencer: one result per transfer, three for phase data.
// Depends on mdtp_pkg; takes finished datapoints from mdtp_parser.
`default_nettype none

module mdtp_result_seq
  import mdtp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         bundle_valid,
  input  mdtp_result_t bundle,
  output logic         bundle_take,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [7:0]   attribute_id,
  output logic [31:0]  reading,
  output logic [1:0]   width_code,
  output logic         last_of_run
);

  logic        out_free;
  logic [1:0]  sub_left;   // phase results still to follow the current one
  logic [7:0]  base_attr;
  logic [23:0] curr;
  logic [23:0] pwr;

  assign out_free    = !out_valid || !out_stall;
  assign bundle_take = bundle_valid && out_free && (!out_valid || last_of_run);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub_left  <= 2'd0;
    end else if (out_free) begin
      if (out_valid && !last_of_run) begin
        if (sub_left == 2'd2) begin
          sub_left <= 2'd1;
        end else begin
          sub_left <= 2'd0;
        end
      end else if (bundle_valid) begin
        out_valid <= 1'b1;
        sub_left  <= bundle.phase ? 2'd2 : 2'd0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (out_valid && !last_of_run) begin
        if (sub_left == 2'd2) begin
          attribute_id <= base_attr + 8'd1;
          reading      <= {8'd0, curr};
          width_code   <= WC_32;
          last_of_run  <= 1'b0;
        end else begin
          attribute_id <= base_attr + 8'd2;
          reading      <= {8'd0, pwr};
          width_code   <= WC_32;
          last_of_run  <= 1'b1;
        end
      end else if (bundle_valid) begin
        attribute_id <= bundle.attr;
        reading      <= bundle.value;
        width_code   <= bundle.wc;
        last_of_run  <= !bundle.phase;
        base_attr    <= bundle.attr;
        curr         <= bundle.curr;
        pwr          <= bundle.pwr;
      end
    end
  end

`ifndef SYNTHESIS
  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> sub_left != 2'd0)
    else $error("non-final result with no follow-up queued");
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run && !out_stall |=> out_valid)
    else $error("phase run broken off");
  a_sub_needs_valid: assert property (@(posedge clk) disable iff (rst)
    sub_left != 2'd0 |-> out_valid)
    else $error("phase results queued without an output");
`endif

endmodule

`default_nettype wire
